[src/assert_macros.svh]
// Assertion helpers for the decoder core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HCBD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define HCBD_ASSERT(lbl, prop, msg) `HCBD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/hcbd_pkg.sv]
`default_nettype none

package hcbd_pkg;

  localparam int unsigned HCBD_SIZE_BITS = 64;
  localparam int unsigned HCBD_LINE_W    = 5;
  localparam int unsigned HCBD_FIFO_DEPTH = 4;
  localparam int unsigned HCBD_FIFO_PTR_W = $clog2(HCBD_FIFO_DEPTH);
  localparam int unsigned HCBD_FIFO_LVL_W = $clog2(HCBD_FIFO_DEPTH + 1);

  localparam logic [HCBD_LINE_W-1:0] HCBD_MAX_LINE_RESET = 5'd16;

  localparam logic [7:0] HCBD_CHAR_CR = 8'h0D;
  localparam logic [7:0] HCBD_CHAR_LF = 8'h0A;

  localparam logic [2:0] HCBD_ST_CONSUMED = 3'd0;
  localparam logic [2:0] HCBD_ST_PAYLOAD  = 3'd1;
  localparam logic [2:0] HCBD_ST_CHUNK    = 3'd2;
  localparam logic [2:0] HCBD_ST_MESSAGE  = 3'd3;
  localparam logic [2:0] HCBD_ST_ERROR    = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } hcbd_item_t;

  typedef struct packed {
    logic [HCBD_FIFO_LVL_W-1:0] level;
    logic                       full;
    logic                       empty;
  } hcbd_fifo_stat_t;

endpackage

`default_nettype wire

[src/hcbd_intf.sv]
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

[src/hcbd_front.sv]
`default_nettype none

module hcbd_front (
  hcbd_in_if.sink               in_chan,
  output logic                  push_valid_o,
  output hcbd_pkg::hcbd_item_t  push_item_o,
  input  wire logic             push_ready_i
);

  logic [7:0] b;
  logic       is_dig;
  logic       is_low;
  logic       is_up;
  logic [7:0] off;

  assign b      = in_chan.byte_in;
  assign is_dig = (b >= 8'h30) && (b <= 8'h39);
  assign is_low = (b >= 8'h61) && (b <= 8'h66);
  assign is_up  = (b >= 8'h41) && (b <= 8'h46);

  always_comb begin
    priority if (is_low) begin
      off = b - 8'h57;
    end else if (is_up) begin
      off = b - 8'h37;
    end else begin
      off = b - 8'h30;
    end
  end

  always_comb begin
    push_item_o.data    = b;
    push_item_o.is_cr   = (b == hcbd_pkg::HCBD_CHAR_CR);
    push_item_o.is_lf   = (b == hcbd_pkg::HCBD_CHAR_LF);
    push_item_o.is_hex  = is_dig || is_low || is_up;
    push_item_o.hex_val = off[3:0];
  end

  assign push_valid_o  = in_chan.valid;
  assign in_chan.ready = push_ready_i;

endmodule

`default_nettype wire

[src/hcbd_fifo.sv]
`default_nettype none

module hcbd_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_valid_i,
  input  wire hcbd_pkg::hcbd_item_t   push_item_i,
  output logic                        push_ready_o,
  output logic                        pop_valid_o,
  output hcbd_pkg::hcbd_item_t        pop_item_o,
  input  wire logic                   pop_ready_i,
  output hcbd_pkg::hcbd_fifo_stat_t   stat_o
);

  localparam int unsigned Depth = hcbd_pkg::HCBD_FIFO_DEPTH;
  localparam int unsigned PtrW  = hcbd_pkg::HCBD_FIFO_PTR_W;
  localparam int unsigned LvlW  = hcbd_pkg::HCBD_FIFO_LVL_W;

  hcbd_pkg::hcbd_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (level_q != LvlW'(Depth));
  assign pop_valid_o  = (level_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      level_d = level_q + LvlW'(1);
    end else if (pop && !push) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_comb begin
    stat_o.level = level_q;
    stat_o.full  = !push_ready_o;
    stat_o.empty = !pop_valid_o;
  end

endmodule

`default_nettype wire

[src/hcbd_back.sv]
`default_nettype none

module hcbd_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [hcbd_pkg::HCBD_LINE_W-1:0]    max_line_length_i,
  input  wire logic                                q_valid_i,
  input  wire hcbd_pkg::hcbd_item_t                q_item_i,
  output logic                                     q_ready_o,
  hcbd_out_if.source                               out_chan
);

  localparam int unsigned SizeW = hcbd_pkg::HCBD_SIZE_BITS;
  localparam int unsigned LineW = hcbd_pkg::HCBD_LINE_W;

  localparam logic [1:0] PhLine  = 2'd0;
  localparam logic [1:0] PhData  = 2'd1;
  localparam logic [1:0] PhClose = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic             cr_seen_q, cr_seen_d;
  logic [LineW-1:0] line_count_q, line_count_d;
  logic             stopped_q, stopped_d;
  logic             digit_seen_q, digit_seen_d;
  logic [SizeW-1:0] size_accum_q, size_accum_d;
  logic [SizeW-1:0] bytes_left_q, bytes_left_d;
  logic             zero_chunk_q, zero_chunk_d;

  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q, status_d;
  logic [7:0] data_q, data_d;

  logic pop;
  logic err;

  assign q_ready_o = !out_valid_q || out_chan.ready;
  assign pop       = q_valid_i && q_ready_o;

  always_comb begin
    phase_d      = phase_q;
    cr_seen_d    = cr_seen_q;
    line_count_d = line_count_q;
    stopped_d    = stopped_q;
    digit_seen_d = digit_seen_q;
    size_accum_d = size_accum_q;
    bytes_left_d = bytes_left_q;
    zero_chunk_d = zero_chunk_q;
    status_d     = hcbd_pkg::HCBD_ST_CONSUMED;
    data_d       = '0;
    err          = 1'b0;

    unique case (phase_q)
      PhLine: begin
        if (cr_seen_q) begin
          if (!q_item_i.is_lf || !digit_seen_q) begin
            err = 1'b1;
          end else begin
            cr_seen_d    = 1'b0;
            bytes_left_d = size_accum_q;
            zero_chunk_d = (size_accum_q == '0);
            phase_d      = (size_accum_q == '0) ? PhClose : PhData;
          end
        end else if (q_item_i.is_cr) begin
          cr_seen_d = 1'b1;
        end else if (line_count_q >= max_line_length_i) begin
          err = 1'b1;
        end else begin
          line_count_d = line_count_q + LineW'(1);
          if (!stopped_q) begin
            if (!q_item_i.is_hex) begin
              stopped_d = 1'b1;
            end else if (size_accum_q[SizeW-1 -: 4] != 4'd0) begin
              err = 1'b1;
            end else begin
              size_accum_d = {size_accum_q[SizeW-5:0], q_item_i.hex_val};
              digit_seen_d = 1'b1;
            end
          end
        end
      end
      PhData: begin
        status_d     = hcbd_pkg::HCBD_ST_PAYLOAD;
        data_d       = q_item_i.data;
        bytes_left_d = bytes_left_q - SizeW'(1);
        if (bytes_left_q == SizeW'(1)) begin
          phase_d = PhClose;
        end
      end
      PhClose: begin
        if (!cr_seen_q) begin
          if (q_item_i.is_cr) begin
            cr_seen_d = 1'b1;
          end else begin
            err = 1'b1;
          end
        end else if (q_item_i.is_lf) begin
          status_d     = zero_chunk_q ? hcbd_pkg::HCBD_ST_MESSAGE : hcbd_pkg::HCBD_ST_CHUNK;
          phase_d      = PhLine;
          cr_seen_d    = 1'b0;
          line_count_d = '0;
          stopped_d    = 1'b0;
          digit_seen_d = 1'b0;
          size_accum_d = '0;
          bytes_left_d = '0;
          zero_chunk_d = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (err) begin
      status_d     = hcbd_pkg::HCBD_ST_ERROR;
      data_d       = '0;
      phase_d      = PhLine;
      cr_seen_d    = 1'b0;
      line_count_d = '0;
      stopped_d    = 1'b0;
      digit_seen_d = 1'b0;
      size_accum_d = '0;
      bytes_left_d = '0;
      zero_chunk_d = 1'b0;
    end
  end

  always_comb begin
    priority if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLine;
      cr_seen_q    <= 1'b0;
      line_count_q <= '0;
      stopped_q    <= 1'b0;
      digit_seen_q <= 1'b0;
      size_accum_q <= '0;
      bytes_left_q <= '0;
      zero_chunk_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q      <= phase_d;
        cr_seen_q    <= cr_seen_d;
        line_count_q <= line_count_d;
        stopped_q    <= stopped_d;
        digit_seen_q <= digit_seen_d;
        size_accum_q <= size_accum_d;
        bytes_left_q <= bytes_left_d;
        zero_chunk_q <= zero_chunk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign out_chan.valid    = out_valid_q;
  assign out_chan.status   = status_q;
  assign out_chan.data_out = data_q;

endmodule

`default_nettype wire

[src/http_chunked_body_decoder_core.sv]
// Chunked body decoder. Each byte of an HTTP chunked body yields exactly one
// result: consumed, payload byte, chunk done, message done or error. The
// decoder sustains one byte per clock cycle while the output accepts its
// results; a result passes first through the four-entry queue between the
// classifier and the decoder state machine and then through the output
// register. The queue lets the input keep flowing for up to four bytes while
// the output is stalled. The back end holds the 64-bit size accumulator and
// byte counter. The maximum size line length is written through cfg_we_i and
// cfg_wdata_i, and resets to sixteen; the user must write it only while no
// transfer is in flight, as the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module http_chunked_body_decoder_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [hcbd_pkg::HCBD_LINE_W-1:0]  cfg_wdata_i,
  hcbd_in_if.sink                                in_chan,
  hcbd_out_if.source                             out_chan
);

  logic [hcbd_pkg::HCBD_LINE_W-1:0] max_line_q;

  logic                        push_valid;
  logic                        push_ready;
  hcbd_pkg::hcbd_item_t        push_item;
  logic                        q_valid;
  logic                        q_ready;
  hcbd_pkg::hcbd_item_t        q_item;
  hcbd_pkg::hcbd_fifo_stat_t   fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= hcbd_pkg::HCBD_MAX_LINE_RESET;
    end else if (cfg_we_i) begin
      max_line_q <= cfg_wdata_i;
    end
  end

  hcbd_front u_front (
    .in_chan      (in_chan),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  hcbd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_ready_i  (q_ready),
    .stat_o       (fifo_stat)
  );

  hcbd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_line_length_i (max_line_q),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_ready_o         (q_ready),
    .out_chan          (out_chan)
  );

  `HCBD_ASSERT(a_data_zero_unless_payload, (out_chan.valid && (out_chan.status != hcbd_pkg::HCBD_ST_PAYLOAD) |-> (out_chan.data_out == 8'd0)), "data_out must be zero outside a payload result")
  `HCBD_ASSERT(a_no_transfer_when_full, (in_chan.valid && in_chan.ready |-> !fifo_stat.full), "input transfer taken while queue is full")
  `HCBD_ASSERT(a_level_bounded, (fifo_stat.level <= hcbd_pkg::HCBD_FIFO_LVL_W'(hcbd_pkg::HCBD_FIFO_DEPTH)), "queue level beyond its depth")
  `HCBD_ASSERT(a_empty_matches_level, (fifo_stat.empty == (fifo_stat.level == '0)), "queue empty flag disagrees with its level")

endmodule

`default_nettype wire

[sim/hcbd_tb_pkg.sv]
`timescale 1ns / 100ps

package hcbd_tb_pkg;
  import hcbd_pkg::*;

  typedef enum logic [1:0] {
    DEC_SIZE_LINE,
    DEC_PAYLOAD,
    DEC_CLOSING
  } dec_phase_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
  } chunk_result_t;

  class chunk_scoreboard;
    logic [HCBD_LINE_W-1:0]    line_limit;
    dec_phase_e                phase;
    logic                      cr_seen;
    logic [HCBD_LINE_W-1:0]    line_count;
    logic                      digits_stopped;
    logic                      digit_seen;
    logic [HCBD_SIZE_BITS-1:0] size_accum;
    logic [HCBD_SIZE_BITS-1:0] bytes_left;
    logic                      zero_chunk;
    chunk_result_t             expected_q[$];
    int                        errors;

    function new();
      line_limit = HCBD_MAX_LINE_RESET;
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = DEC_SIZE_LINE;
      cr_seen = 1'b0;
      line_count = '0;
      digits_stopped = 1'b0;
      digit_seen = 1'b0;
      size_accum = '0;
      bytes_left = '0;
      zero_chunk = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= "0" && c <= "9") begin
        v = c[3:0];
        return 1'b1;
      end
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
        v = c[3:0] + 4'd9;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [2:0] size_line_step(input logic [7:0] c);
      logic [3:0] d;
      if (cr_seen) begin
        if (c != HCBD_CHAR_LF || !digit_seen) return HCBD_ST_ERROR;
        cr_seen = 1'b0;
        bytes_left = size_accum;
        zero_chunk = (size_accum == '0);
        phase = zero_chunk ? DEC_CLOSING : DEC_PAYLOAD;
        return HCBD_ST_CONSUMED;
      end
      if (c == HCBD_CHAR_CR) begin
        cr_seen = 1'b1;
        return HCBD_ST_CONSUMED;
      end
      if (line_count >= line_limit) return HCBD_ST_ERROR;
      line_count = line_count + 1'b1;
      if (!digits_stopped) begin
        if (!hex_nibble(c, d)) begin
          digits_stopped = 1'b1;
        end else begin
          if (size_accum[HCBD_SIZE_BITS-1 -: 4] != 4'd0) return HCBD_ST_ERROR;
          size_accum = {size_accum[HCBD_SIZE_BITS-5:0], d};
          digit_seen = 1'b1;
        end
      end
      return HCBD_ST_CONSUMED;
    endfunction

    function void note_byte(input logic [7:0] c);
      chunk_result_t r;
      r.status = HCBD_ST_CONSUMED;
      r.data = '0;
      case (phase)
        DEC_SIZE_LINE: r.status = size_line_step(c);
        DEC_PAYLOAD: begin
          r.status = HCBD_ST_PAYLOAD;
          r.data = c;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) phase = DEC_CLOSING;
        end
        DEC_CLOSING: begin
          if (!cr_seen) begin
            if (c == HCBD_CHAR_CR) cr_seen = 1'b1;
            else r.status = HCBD_ST_ERROR;
          end else if (c == HCBD_CHAR_LF) begin
            r.status = zero_chunk ? HCBD_ST_MESSAGE : HCBD_ST_CHUNK;
            clear_state();
          end else begin
            r.status = HCBD_ST_ERROR;
          end
        end
        default: r.status = HCBD_ST_ERROR;
      endcase
      if (r.status == HCBD_ST_ERROR) clear_state();
      expected_q.push_back(r);
    endfunction

    task report(input string msg);
      $display("tb_top: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(input logic [2:0] status, input logic [7:0] data);
      chunk_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("status %0d data %02h with nothing expected", status, data));
        return;
      end
      exp_r = expected_q.pop_front();
      if (status !== exp_r.status)
        report($sformatf("status %0d, expected %0d", status, exp_r.status));
      if (data !== exp_r.data)
        report($sformatf("data_out %02h, expected %02h", data, exp_r.data));
    endtask
  endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hcbd_pkg::*;
  import hcbd_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 540;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned STALL_LIMIT = 400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we;
  logic [HCBD_LINE_W-1:0] cfg_wdata;
  bit                     tx_idle = 1'b1;
  bit                     rx_idle = 1'b1;
  int unsigned            sent_count = 0;
  int unsigned            stall_cycles = 0;
  chunk_scoreboard        sb = new();

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_chan     (in_if),
    .out_chan    (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_result(out_if.status, out_if.data_out);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    sent_count++;
  endtask

  task automatic send_seq(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_line_limit(input logic [HCBD_LINE_W-1:0] v);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.line_limit = v;
  endtask

  // In these strings '<' stands for CR and '>' for LF.
  function automatic void add_text(ref logic [7:0] s[$], input string t);
    for (int i = 0; i < t.len(); i++) begin
      case (t[i])
        "<": s.push_back(HCBD_CHAR_CR);
        ">": s.push_back(HCBD_CHAR_LF);
        default: s.push_back(t[i]);
      endcase
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] ext_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == HCBD_CHAR_CR);
    return b;
  endfunction

  function automatic void add_chunk(ref logic [7:0] s[$], input int unsigned size,
                                    input int unsigned limit);
    int unsigned nd;
    int unsigned room;
    int unsigned lz;
    int unsigned ext;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    room = (limit > nd) ? limit - nd : 0;
    lz = $urandom_range(0, (room < 3) ? room : 3);
    room -= lz;
    repeat (lz) s.push_back("0");
    for (int i = nd - 1; i >= 0; i--) s.push_back(hex_char(4'((size >> (4 * i)) & 15)));
    if (room >= 1 && $urandom_range(0, 2) == 0) begin
      ext = $urandom_range(0, (room - 1 < 4) ? room - 1 : 4);
      s.push_back(";");
      repeat (ext) s.push_back(ext_char());
    end
    add_text(s, "<>");
    repeat (size) s.push_back(8'($urandom_range(0, 255)));
    add_text(s, "<>");
  endfunction

  task automatic run_random_phase(input int unsigned items, input int unsigned limit);
    logic [7:0]  s[$];
    int unsigned target;
    int unsigned kind;
    int unsigned pos;
    target = sent_count + items;
    while (sent_count < target) begin
      s.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(0, 2)) add_chunk(s, $urandom_range(1, 12), limit);
        add_chunk(s, 0, limit);
      end else if (kind < 85) begin
        add_chunk(s, $urandom_range(0, 6), limit);
        pos = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 2))
          0: s[pos] = 8'($urandom_range(0, 255));
          1: repeat (s.size() - pos - 1) void'(s.pop_back());
          default: s.delete(pos);
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
      end
      send_seq(s);
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end
  endtask

  initial begin
    logic [7:0]  s[$];
    int unsigned lim;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text(s, "2;x<>");
    s.push_back(8'h00);
    s.push_back(8'hFF);
    add_text(s, "<>0<><>1<X<>1<>AB1<>A<X");
    send_seq(s);

    s.delete();
    write_line_limit(5'd1);
    add_text(s, "12");
    add_chunk(s, 5, 1);
    send_seq(s);

    s.delete();
    write_line_limit(5'd0);
    add_text(s, "0<>");
    send_seq(s);

    s.delete();
    write_line_limit(5'd31);
    add_text(s, "10000000000000000");
    add_text(s, "00000000000000000000000000000000");
    add_text(s, "0000000000000000000000000000003<>abc<>");
    send_seq(s);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lim = 16;
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          lim = 1;
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          lim = 31;
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        default: begin
          lim = $urandom_range(1, 16);
          tx_idle = $urandom_range(0, 1);
          rx_idle = $urandom_range(0, 1);
        end
      endcase
      write_line_limit(lim[HCBD_LINE_W-1:0]);
      run_random_phase(ITEM_TARGET / PHASES, lim);
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
